// ----- rtl/spm_pkg.sv -----
package spm_pkg;

  // Default table sizing
  localparam int unsigned SegmentsPerGroupDefault = 16;
  localparam int unsigned MaxPeersDefault         = 64;

  // Field widths
  localparam int unsigned AddrW      = 32;
  localparam int unsigned PeerIdxW   = 6;
  localparam int unsigned PeerMaskW  = 64;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutUserW   = 2;

  // Classful masks and class boundaries on the first octet
  localparam logic [AddrW-1:0] MaskClassA = 32'hff00_0000;
  localparam logic [AddrW-1:0] MaskClassB = 32'hffff_0000;
  localparam logic [AddrW-1:0] MaskClassC = 32'hffff_ff00;
  localparam logic [7:0]       ClassBLow  = 8'd128;
  localparam logic [7:0]       ClassCLow  = 8'd192;

  typedef enum logic {
    OpAdd   = 1'b0,
    OpQuery = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusMiss = 2'd1,
    StatusFull = 2'd2
  } status_e;

  // Mask an address down to its classful segment key
  function automatic logic [AddrW-1:0] class_segment(input logic [AddrW-1:0] addr);
    logic [7:0] top;
    top = addr[AddrW-1 -: 8];
    if (top < ClassBLow) begin
      return addr & MaskClassA;
    end else if (top < ClassCLow) begin
      return addr & MaskClassB;
    end
    return addr & MaskClassC;
  endfunction

endpackage

// ----- rtl/subnet_peer_group_marker.sv -----
// Classful subnet peer table with a primary and a backup group.
//
// Input stream (s_axis_*): one transfer per item. tuser carries the opcode
// (add or query) and the group; tdata carries the IPv4 address and the peer
// index. An add masks the address by its class (/8, /16 or /24), finds or
// allocates the segment entry in the chosen group and sets the peer's bit.
// A query searches the primary group, then the backup group.
// Output stream (m_axis_*): exactly one transfer per input item, in order;
// tuser holds the status (ok/hit, miss, group full), tdata the peer bitmap.
//
// An item passes from the input transfer through one input register, then
// the table match, update and result register. One item is accepted every
// cycle while the output is not stalled; each item sees every table update
// of the items before it, since the match and the update share one cycle.
// When the receiver stalls, the result holds in the output register and the
// input register fills; s_axis_tready then drops until the result is taken.
// Reset clears all entry valid bits and the valid flags of both pipeline
// registers; keys and bitmaps need no clearing, so the block is ready in the cycle after reset.
module subnet_peer_group_marker #(
  parameter int unsigned SEGMENTS_PER_GROUP = spm_pkg::SegmentsPerGroupDefault,
  parameter int unsigned MAX_PEERS          = spm_pkg::MaxPeersDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] ip_address, [37:32] peer_index, [39:38] zero
  input  logic [spm_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] opcode, [1] backup_group
  input  logic [spm_pkg::InUserW-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [63:0] peer_mask
  output logic [spm_pkg::PeerMaskW-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [spm_pkg::OutUserW-1:0]   m_axis_tuser
);

  localparam int unsigned Depth = 2 * SEGMENTS_PER_GROUP;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // Table storage: entries below SEGMENTS_PER_GROUP are primary, the rest backup
  logic [spm_pkg::AddrW-1:0] key_q     [Depth];
  logic [MAX_PEERS-1:0]      members_q [Depth];
  logic [Depth-1:0]          valid_q;

  // Input register
  logic                         s1_valid_q;
  spm_pkg::opcode_e             s1_op_q;
  logic                         s1_backup_q;
  logic [spm_pkg::AddrW-1:0]    s1_addr_q;
  logic [spm_pkg::PeerIdxW-1:0] s1_peer_q;

  // Result register
  logic                          out_valid_q;
  spm_pkg::status_e              out_status_q, out_status_d;
  logic [spm_pkg::PeerMaskW-1:0] out_mask_q, out_mask_d;

  logic advance;
  logic in_xfer;

  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Match and allocation
  logic [spm_pkg::AddrW-1:0] seg_key;
  logic                      hit_prim, hit_back, free_found;
  logic [IdxW-1:0]           prim_idx, back_idx, free_idx;
  logic                      grp_hit;
  logic [IdxW-1:0]           rd_idx;
  logic [MAX_PEERS-1:0]      rd_members;
  logic                      peer_ok;
  logic [MAX_PEERS-1:0]      peer_bit;
  logic                      wr_or, wr_alloc;
  logic [IdxW-1:0]           wr_idx;

  always_comb begin
    seg_key    = spm_pkg::class_segment(s1_addr_q);
    hit_prim   = 1'b0;
    hit_back   = 1'b0;
    free_found = 1'b0;
    prim_idx   = '0;
    back_idx   = '0;
    free_idx   = '0;
    // Walk downwards so that the lowest entry wins
    for (int i = SEGMENTS_PER_GROUP - 1; i >= 0; i--) begin
      if (valid_q[i] && (key_q[i] == seg_key)) begin
        hit_prim = 1'b1;
        prim_idx = IdxW'(i);
      end
      if (valid_q[SEGMENTS_PER_GROUP + i] && (key_q[SEGMENTS_PER_GROUP + i] == seg_key)) begin
        hit_back = 1'b1;
        back_idx = IdxW'(SEGMENTS_PER_GROUP + i);
      end
      if (s1_backup_q) begin
        if (!valid_q[SEGMENTS_PER_GROUP + i]) begin
          free_found = 1'b1;
          free_idx   = IdxW'(SEGMENTS_PER_GROUP + i);
        end
      end else if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end

    peer_ok  = ({1'b0, s1_peer_q} < (spm_pkg::PeerIdxW + 1)'(MAX_PEERS));
    peer_bit = MAX_PEERS'(1) << s1_peer_q;

    // One read port: add reads its own group, query prefers primary
    if (s1_op_q == spm_pkg::OpAdd) begin
      grp_hit = s1_backup_q ? hit_back : hit_prim;
      rd_idx  = s1_backup_q ? back_idx : prim_idx;
    end else begin
      grp_hit = hit_prim || hit_back;
      rd_idx  = hit_prim ? prim_idx : back_idx;
    end
    rd_members = members_q[rd_idx];

    wr_or        = 1'b0;
    wr_alloc     = 1'b0;
    wr_idx       = rd_idx;
    out_status_d = spm_pkg::StatusOk;
    out_mask_d   = '0;
    if (s1_op_q == spm_pkg::OpAdd) begin
      if (peer_ok) begin
        if (grp_hit) begin
          wr_or = 1'b1;
        end else if (free_found) begin
          wr_alloc = 1'b1;
          wr_idx   = free_idx;
        end else begin
          out_status_d = spm_pkg::StatusFull;
        end
      end
    end else if (grp_hit) begin
      out_mask_d = spm_pkg::PeerMaskW'(rd_members);
    end else begin
      out_status_d = spm_pkg::StatusMiss;
    end
  end

  // Table update, committed as the item moves to the result register
  always_ff @(posedge clk_i) begin
    if (advance && wr_or) begin
      members_q[wr_idx] <= rd_members | peer_bit;
    end
    if (advance && wr_alloc) begin
      members_q[wr_idx] <= peer_bit;
      key_q[wr_idx]     <= seg_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance && wr_alloc) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= spm_pkg::opcode_e'(s_axis_tuser[0]);
      s1_backup_q <= s_axis_tuser[1];
      s1_addr_q   <= s_axis_tdata[spm_pkg::AddrW-1:0];
      s1_peer_q   <= s_axis_tdata[spm_pkg::AddrW +: spm_pkg::PeerIdxW];
    end
    if (advance) begin
      out_status_q <= out_status_d;
      out_mask_q   <= out_mask_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mask_q;
  assign m_axis_tuser  = out_status_q;

endmodule
